>>> sv/frequency_ranked_list_core_macros.svh
`ifndef FREQUENCY_RANKED_LIST_CORE_MACROS_SVH
`define FREQUENCY_RANKED_LIST_CORE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define FRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define FRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/frl_pkg.sv
package frl_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int TOP_COUNT   = 6;
    localparam int COUNT_W     = 16;
    localparam int RANK_W      = $clog2(NUM_ENTRIES);
    localparam int TOP_W       = $clog2(TOP_COUNT);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] MODE_BUMP   = 2'd0;
    localparam logic [1:0] MODE_PRESET = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_index;
        logic [15:0] preset_value;
    } t_item;

    typedef struct packed {
        logic        order_changed;
        logic [5:0]  new_rank;
        logic [15:0] entry_count;
        logic [5:0]  top_first;
        logic [5:0]  top_second;
        logic [5:0]  top_third;
        logic [5:0]  top_fourth;
        logic [5:0]  top_fifth;
        logic [5:0]  top_sixth;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_WCNT,
        ST_WCMP,
        ST_PLACE,
        ST_DONE
    } t_state;

endpackage

>>> sv/frequency_ranked_list_core.sv
// Ranked use-count list of 64 entries. An item is taken when start is high and busy is low;
// its result appears on o_result for exactly one cycle with o_done high, and cannot be held
// off. A clear, a query, or a bump/preset of the entry already at rank 0 passes from accept
// through the fetch and evaluate states to the result. Any other bump or preset walks the ranks
// above the entry until a larger count stops it or it reaches rank 0, then places the entry:
// each rank examined costs one read of the ranking memory followed by one read of the count
// memory, both with registered read data. busy stays high until the result cycle ends.
module frequency_ranked_list_core
    import frl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

`include "frequency_ranked_list_core_macros.svh"

    // control
    t_state r_state, n_state;

    // captured item and walk registers
    logic [1:0]         r_mode;
    logic [RANK_W-1:0]  r_e;
    logic [COUNT_W-1:0] r_pv;
    logic               r_valid;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [RANK_W-1:0]  r_rank0, n_rank0;
    logic [RANK_W-1:0]  r_pos, n_pos;
    logic [RANK_W-1:0]  r_m, n_m;

    // top ranks shadow
    logic [RANK_W-1:0]  r_top [TOP_COUNT];

    // memories with per-entry valid bits
    logic [RANK_W-1:0]  r_ord_mem [NUM_ENTRIES];
    logic [RANK_W-1:0]  r_roe_mem [NUM_ENTRIES];
    logic [COUNT_W-1:0] r_cnt_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_ord_vld, r_roe_vld, r_cnt_vld;

    logic [RANK_W-1:0]  r_ord_q, r_ord_qa, r_roe_q, r_roe_qa;
    logic [COUNT_W-1:0] r_cnt_q;
    logic               r_ord_hit, r_roe_hit, r_cnt_hit;

    logic [RANK_W-1:0]  ord_raddr, roe_raddr, cnt_raddr;
    logic               ord_we, roe_we, cnt_we, cnt_clr;
    logic [RANK_W-1:0]  ord_waddr, ord_wdata, roe_waddr, roe_wdata, cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;

    logic [RANK_W-1:0]  ord_rd, roe_rd;
    logic [COUNT_W-1:0] cnt_rd;
    logic               accept, moving;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // entries never written read as their reset value
    assign ord_rd = r_ord_hit ? r_ord_q : r_ord_qa;
    assign roe_rd = r_roe_hit ? r_roe_q : r_roe_qa;
    assign cnt_rd = r_cnt_hit ? r_cnt_q : '0;

    assign moving = r_valid && ((r_mode == MODE_BUMP) || (r_mode == MODE_PRESET));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_EVAL;
            ST_EVAL: begin
                if (moving && (roe_rd != '0)) begin
                    n_state = ST_WCNT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WCNT: n_state = ST_WCMP;
            ST_WCMP: begin
                if ((cnt_rd <= r_cnt) && (r_pos != RANK_W'(1))) begin
                    n_state = ST_WCNT;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_rank0   = r_rank0;
        n_pos     = r_pos;
        n_m       = r_m;
        ord_raddr = r_pos - RANK_W'(2);
        roe_raddr = r_e;
        cnt_raddr = r_e;
        ord_we    = 1'b0;
        ord_waddr = r_pos;
        ord_wdata = r_m;
        roe_we    = 1'b0;
        roe_waddr = r_m;
        roe_wdata = r_pos;
        cnt_we    = 1'b0;
        cnt_waddr = r_e;
        cnt_wdata = n_cnt;
        cnt_clr   = 1'b0;
        case (r_state)
            ST_EVAL: begin
                case (r_mode)
                    MODE_BUMP:   n_cnt = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1);
                    MODE_PRESET: n_cnt = r_pv;
                    MODE_CLEAR:  n_cnt = '0;
                    default:     n_cnt = cnt_rd;
                endcase
                cnt_wdata = n_cnt;
                cnt_we    = moving;
                cnt_clr   = (r_mode == MODE_CLEAR);
                n_rank0   = roe_rd;
                n_pos     = roe_rd;
                ord_raddr = roe_rd - RANK_W'(1);
            end
            ST_WCNT: begin
                n_m       = ord_rd;
                cnt_raddr = ord_rd;
            end
            ST_WCMP: begin
                cnt_raddr = r_m;
                // predecessor not ahead in count: shift it down one rank
                if (cnt_rd <= r_cnt) begin
                    ord_we = 1'b1;
                    roe_we = 1'b1;
                    n_pos  = r_pos - RANK_W'(1);
                end
            end
            ST_PLACE: begin
                ord_we    = 1'b1;
                ord_wdata = r_e;
                roe_we    = 1'b1;
                roe_waddr = r_e;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ord_vld <= '0;
            r_roe_vld <= '0;
            r_cnt_vld <= '0;
            for (int k = 0; k < TOP_COUNT; k++) begin
                r_top[k] <= RANK_W'(k);
            end
        end else begin
            r_state <= n_state;
            if (ord_we) begin
                r_ord_vld[ord_waddr] <= 1'b1;
                if (32'(ord_waddr) < TOP_COUNT) begin
                    r_top[ord_waddr[TOP_W-1:0]] <= ord_wdata;
                end
            end
            if (roe_we) begin
                r_roe_vld[roe_waddr] <= 1'b1;
            end
            if (cnt_clr) begin
                r_cnt_vld <= '0;
            end else if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_item.mode;
            r_e     <= i_item.entry_index[RANK_W-1:0];
            r_pv    <= i_item.preset_value[COUNT_W-1:0];
            r_valid <= (32'(i_item.entry_index) < NUM_ENTRIES);
        end
        r_cnt   <= n_cnt;
        r_rank0 <= n_rank0;
        r_pos   <= n_pos;
        r_m     <= n_m;
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_ord_mem[ord_waddr] <= ord_wdata;
        end
        if (roe_we) begin
            r_roe_mem[roe_waddr] <= roe_wdata;
        end
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_ord_q   <= r_ord_mem[ord_raddr];
        r_ord_hit <= r_ord_vld[ord_raddr];
        r_ord_qa  <= ord_raddr;
        r_roe_q   <= r_roe_mem[roe_raddr];
        r_roe_hit <= r_roe_vld[roe_raddr];
        r_roe_qa  <= roe_raddr;
        r_cnt_q   <= r_cnt_mem[cnt_raddr];
        r_cnt_hit <= r_cnt_vld[cnt_raddr];
    end

    always_comb begin
        o_done                 = (r_state == ST_DONE);
        o_result.order_changed = r_valid && (r_pos != r_rank0);
        o_result.new_rank      = r_valid ? 6'(r_pos) : '0;
        o_result.entry_count   = r_valid ? 16'(r_cnt) : '0;
        o_result.top_first     = 6'(r_top[0]);
        o_result.top_second    = 6'(r_top[1]);
        o_result.top_third     = 6'(r_top[2]);
        o_result.top_fourth    = 6'(r_top[3]);
        o_result.top_fifth     = 6'(r_top[4]);
        o_result.top_sixth     = 6'(r_top[5]);
    end

    `FRL_ASSERT_NOW(a_done_while_busy, o_done, busy, "result strobe outside a busy item")
    `FRL_ASSERT_NEXT(a_accept_fetch, accept, r_state == ST_FETCH, "accepted item did not start")
    `FRL_ASSERT_NEXT(a_walk_climbs, r_state == ST_WCMP, r_pos <= $past(r_pos),
                     "walk moved the entry down")
    `FRL_ASSERT_NOW(a_change_is_up, o_done && o_result.order_changed, r_pos < r_rank0,
                    "order change reported without a climb")

endmodule

>>> tb/tb_frequency_ranked_list_core.sv
`timescale 1ns / 1ps

module tb_frequency_ranked_list_core;
    import frl_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_plan_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // shadow copy of the ranking state
    logic [5:0]  rank_slot [NUM_ENTRIES];
    logic [15:0] use_cnt [NUM_ENTRIES];
    logic [5:0]  entry_rank [NUM_ENTRIES];

    t_result   expected_rankings [$];
    t_plan_row plan [];
    t_result   want;
    int        errors = 0;
    int        idle_cycles = 0;

    frequency_ranked_list_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result rank_update(t_item it);
        t_result    r;
        logic [5:0] e;
        int         from;
        int         to;
        logic       moved;
        e = it.entry_index;
        moved = 1'b0;
        case (it.mode)
            MODE_CLEAR: begin
                foreach (use_cnt[i]) use_cnt[i] = '0;
            end
            MODE_BUMP, MODE_PRESET: begin
                if (it.mode == MODE_PRESET) begin
                    use_cnt[e] = it.preset_value;
                end else if (use_cnt[e] != COUNT_MAX) begin
                    use_cnt[e] = use_cnt[e] + 16'd1;
                end
                // climb past every neighbor above whose count is not greater
                from = entry_rank[e];
                to = from;
                while (to > 0 && use_cnt[rank_slot[to-1]] <= use_cnt[e]) to--;
                moved = (to != from);
                for (int k = from; k > to; k--) begin
                    rank_slot[k] = rank_slot[k-1];
                    entry_rank[rank_slot[k]] = 6'(k);
                end
                rank_slot[to] = e;
                entry_rank[e] = 6'(to);
            end
            default: ;
        endcase
        r.order_changed = moved;
        r.new_rank      = entry_rank[e];
        r.entry_count   = use_cnt[e];
        r.top_first     = rank_slot[0];
        r.top_second    = rank_slot[1];
        r.top_third     = rank_slot[2];
        r.top_fourth    = rank_slot[3];
        r.top_fifth     = rank_slot[4];
        r.top_sixth     = rank_slot[5];
        return r;
    endfunction

    function automatic t_item random_item(logic [5:0] hot);
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 66)      it.mode = MODE_BUMP;
        else if (pick < 84) it.mode = MODE_PRESET;
        else if (pick < 96) it.mode = MODE_QUERY;
        else                it.mode = MODE_CLEAR;
        // most traffic lands on a small hot set so rankings keep shifting
        if ($urandom_range(0, 9) < 6) it.entry_index = hot + 6'($urandom_range(0, 7));
        else                          it.entry_index = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0:       it.preset_value = 16'($urandom_range(0, 15));
            1:       it.preset_value = 16'($urandom);
            2:       it.preset_value = COUNT_MAX;
            default: it.preset_value = COUNT_MAX - 16'($urandom_range(0, 3));
        endcase
        return it;
    endfunction

    // hold the beat until the block takes it; start is left high for the caller
    task automatic send_beat(t_item it, bit typed, t_result typed_want);
        t_result predicted;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = rank_update(it);
        expected_rankings.push_back(typed ? typed_want : predicted);
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rankings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                want = expected_rankings.pop_front();
                check_field("order_changed", want.order_changed, o_result.order_changed);
                check_field("new_rank", want.new_rank, o_result.new_rank);
                check_field("entry_count", want.entry_count, o_result.entry_count);
                check_field("top_first", want.top_first, o_result.top_first);
                check_field("top_second", want.top_second, o_result.top_second);
                check_field("top_third", want.top_third, o_result.top_third);
                check_field("top_fourth", want.top_fourth, o_result.top_fourth);
                check_field("top_fifth", want.top_fifth, o_result.top_fifth);
                check_field("top_sixth", want.top_sixth, o_result.top_sixth);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL frequency_ranked_list_core");
                $finish;
            end
        end
    end

    initial begin
        int         sent;
        int         burst;
        bit         paused;
        logic [5:0] hot;

        for (int i = 0; i < NUM_ENTRIES; i++) begin
            rank_slot[i]  = 6'(i);
            entry_rank[i] = 6'(i);
            use_cnt[i]    = '0;
        end

        plan = new[20];
        plan[0]  = '{'{MODE_QUERY, 6'd5, 16'h0000}, 1'b1,
                     '{1'b0, 6'd5, 16'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5}};
        plan[1]  = '{'{MODE_BUMP, 6'd0, 16'h0000}, 1'b1,
                     '{1'b0, 6'd0, 16'd1, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5}};
        // equal counts above do not block the climb
        plan[2]  = '{'{MODE_BUMP, 6'd63, 16'h0000}, 1'b1,
                     '{1'b1, 6'd0, 16'd1, 6'd63, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4}};
        plan[3]  = '{'{MODE_PRESET, 6'd62, 16'hFFFF}, 1'b1,
                     '{1'b1, 6'd0, 16'hFFFF, 6'd62, 6'd63, 6'd0, 6'd1, 6'd2, 6'd3}};
        // bump at full count keeps the count
        plan[4]  = '{'{MODE_BUMP, 6'd62, 16'h0000}, 1'b1,
                     '{1'b0, 6'd0, 16'hFFFF, 6'd62, 6'd63, 6'd0, 6'd1, 6'd2, 6'd3}};
        plan[5]  = '{'{MODE_PRESET, 6'd63, 16'hFFFF}, 1'b1,
                     '{1'b1, 6'd0, 16'hFFFF, 6'd63, 6'd62, 6'd0, 6'd1, 6'd2, 6'd3}};
        plan[6]  = '{'{MODE_PRESET, 6'd63, 16'h0000}, 1'b1,
                     '{1'b0, 6'd0, 16'd0, 6'd63, 6'd62, 6'd0, 6'd1, 6'd2, 6'd3}};
        plan[7]  = '{'{MODE_PRESET, 6'd62, 16'h0000}, 1'b1,
                     '{1'b1, 6'd0, 16'd0, 6'd62, 6'd63, 6'd0, 6'd1, 6'd2, 6'd3}};
        plan[8]  = '{'{MODE_PRESET, 6'd0, 16'h5555}, 1'b0, '0};
        plan[9]  = '{'{MODE_PRESET, 6'd42, 16'hAAAA}, 1'b0, '0};
        plan[10] = '{'{MODE_BUMP, 6'd21, 16'hFFFF}, 1'b0, '0};
        plan[11] = '{'{MODE_QUERY, 6'd63, 16'hA5A5}, 1'b0, '0};
        plan[12] = '{'{MODE_PRESET, 6'd42, 16'h0001}, 1'b0, '0};
        plan[13] = '{'{MODE_CLEAR, 6'd42, 16'hFFFF}, 1'b0, '0};
        plan[14] = '{'{MODE_BUMP, 6'd42, 16'h0000}, 1'b0, '0};
        plan[15] = '{'{MODE_PRESET, 6'd1, 16'hFFFF}, 1'b0, '0};
        plan[16] = '{'{MODE_BUMP, 6'd1, 16'h0000}, 1'b0, '0};
        plan[17] = '{'{MODE_PRESET, 6'd40, 16'hFFFE}, 1'b0, '0};
        plan[18] = '{'{MODE_CLEAR, 6'd63, 16'h0000}, 1'b0, '0};
        plan[19] = '{'{MODE_QUERY, 6'd0, 16'h0000}, 1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) send_beat(plan[i].item, plan[i].typed, plan[i].want);

        sent = 0;
        paused = 1'b0;
        hot = 6'($urandom_range(0, 63));
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) hot = 6'($urandom_range(0, 63));
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                send_beat(random_item(hot), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                // let the block drain completely once
                paused = 1'b1;
                start <= 1'b0;
                while (expected_rankings.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end

        start <= 1'b0;
        while (expected_rankings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS frequency_ranked_list_core");
        end else begin
            $display("FAIL frequency_ranked_list_core");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/frl_pkg.sv
sv/frequency_ranked_list_core.sv
tb/tb_frequency_ranked_list_core.sv
